// File: sv/lsrt_pkg.sv
`timescale 1ns / 1ps
package lsrt_pkg;

  localparam int NODE_COUNT_DEF = 16;
  localparam int COST_WIDTH_DEF = 16;

  localparam int DIST_W = 17;
  localparam logic [DIST_W-1:0] UNREACH = 17'd99999;
  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  localparam logic [1:0] OP_LOCAL = 2'd0;
  localparam logic [1:0] OP_MSG   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic KIND_FLOOD  = 1'b0;
  localparam logic KIND_ANSWER = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  link_src;
    logic [3:0]  link_dst;
    logic [15:0] link_cost;
    logic [15:0] link_age;
    logic [3:0]  query_dest;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  msg_src;
    logic [3:0]  msg_dst;
    logic [15:0] msg_cost;
    logic [15:0] msg_age;
    logic [3:0]  next_hop;
    logic        reachable;
    logic [16:0] path_cost;
  } out_word_t;

  typedef struct packed {
    logic load_in;
    logic clr_wr;
    logic upd_rd;
    logic upd_wr;
    logic q_init;
    logic relax;
    logic next;
    logic walk_start;
    logic walk_step;
    logic res_unreach;
    logic res_self;
    logic res_hop;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [1:0] op;
    logic       nodes_ok;
    logic       query_ok;
    logic       self_q;
    logic       upd_emit;
    logic       relax_done;
    logic       pick_vld;
    logic       pred_ok;
    logic       walk_stop;
    logic       out_free;
  } sts_t;

endpackage

// File: sv/link_state_route_table.sv
`timescale 1ns / 1ps
// channel  | ports                                | word
// input    | in_valid, in_stall, in_word          | in_word_t: opcode, link, age, query
// result   | out_valid, out_stall, out_word       | out_word_t: flood or next-hop answer
// config   | cfg_wr_en, cfg_wr_data               | own_node
// After reset a clearing pass writes every table entry and so marks every link unknown;
// input is stalled meanwhile. Link updates go through the table read and then the
// table write. A query runs a shortest-path search, in which each settled node scans
// one table row, and then a predecessor walk from the destination toward the own node.
// One word is in work at a time; a finished word waits in the output register.
module link_state_route_table #(
  parameter int NODE_COUNT = lsrt_pkg::NODE_COUNT_DEF,
  parameter int COST_WIDTH = lsrt_pkg::COST_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsrt_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output lsrt_pkg::out_word_t out_word
);

  lsrt_pkg::cmd_t cmd;
  lsrt_pkg::sts_t sts;

  lsrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lsrt_dp #(
    .NODE_COUNT (NODE_COUNT),
    .COST_WIDTH (COST_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_word     (in_word),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_word    (out_word)
  );

`ifndef NO_ASSERTIONS
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled during clearing pass");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while one is in work");
  a_one_table_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_wr, cmd.upd_rd, cmd.upd_wr, cmd.relax, cmd.walk_step}))
    else $error("conflicting table operations");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> !$rose(cmd.emit) || !out_stall)
    else $error("result loaded over a waiting word");
`endif

endmodule

// File: sv/lsrt_ctrl.sv
`timescale 1ns / 1ps
module lsrt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lsrt_pkg::sts_t sts,
  output lsrt_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_DISPATCH = 11'b000_0000_0100,
    S_UPD_RD   = 11'b000_0000_1000,
    S_UPD_WR   = 11'b000_0001_0000,
    S_Q_INIT   = 11'b000_0010_0000,
    S_RELAX    = 11'b000_0100_0000,
    S_NEXT     = 11'b000_1000_0000,
    S_WALK0    = 11'b001_0000_0000,
    S_WALK     = 11'b010_0000_0000,
    S_EMIT     = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.op)
          lsrt_pkg::OP_LOCAL, lsrt_pkg::OP_MSG: begin
            state_nxt = sts.nodes_ok ? S_UPD_RD : S_IDLE;
          end
          lsrt_pkg::OP_QUERY: begin
            if (!sts.query_ok) begin
              cmd.res_unreach = 1'b1;
              state_nxt       = S_EMIT;
            end else if (sts.self_q) begin
              cmd.res_self = 1'b1;
              state_nxt    = S_EMIT;
            end else begin
              state_nxt = S_Q_INIT;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_UPD_RD: begin
        cmd.upd_rd = 1'b1;
        state_nxt  = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.upd_wr = 1'b1;
        state_nxt  = sts.upd_emit ? S_EMIT : S_IDLE;
      end
      S_Q_INIT: begin
        cmd.q_init = 1'b1;
        state_nxt  = S_RELAX;
      end
      S_RELAX: begin
        cmd.relax = 1'b1;
        if (sts.relax_done) state_nxt = sts.pick_vld ? S_NEXT : S_WALK0;
      end
      S_NEXT: begin
        cmd.next  = 1'b1;
        state_nxt = S_RELAX;
      end
      S_WALK0: begin
        cmd.walk_start = 1'b1;
        if (sts.pred_ok) begin
          state_nxt = S_WALK;
        end else begin
          cmd.res_unreach = 1'b1;
          state_nxt       = S_EMIT;
        end
      end
      S_WALK: begin
        if (sts.walk_stop) begin
          cmd.res_hop = 1'b1;
          state_nxt   = S_EMIT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// File: sv/lsrt_dp.sv
`timescale 1ns / 1ps
module lsrt_dp #(
  parameter int NODE_COUNT = lsrt_pkg::NODE_COUNT_DEF,
  parameter int COST_WIDTH = lsrt_pkg::COST_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [3:0]          cfg_wr_data,
  input  lsrt_pkg::in_word_t  in_word,
  input  lsrt_pkg::cmd_t      cmd,
  output lsrt_pkg::sts_t      sts,
  input  logic                out_stall,
  output logic                out_valid,
  output lsrt_pkg::out_word_t out_word
);

  localparam int NB    = $clog2(NODE_COUNT);
  localparam int DEPTH = NODE_COUNT * NODE_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = COST_WIDTH + 17;
  localparam int DW    = lsrt_pkg::DIST_W;
  localparam int SW    = ((COST_WIDTH > DW) ? COST_WIDTH : DW) + 1;

  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] mem_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra, upd_addr, rel_addr, clr_r;
  logic [MW-1:0] mem_wd;

  lsrt_pkg::in_word_t  in_r;
  lsrt_pkg::out_word_t res_r, out_word_r;
  logic                out_valid_r;
  logic [3:0]          own_r;

  logic [DW-1:0]         dist_r [NODE_COUNT];
  logic [NB-1:0]         pred_r [NODE_COUNT];
  logic [NODE_COUNT-1:0] pred_vld_r, settled_r, frontier_r;
  logic [NB:0]           cnt_r;
  logic [NB-1:0]         x_r, rv_r, pick_r, hop_r, root;
  logic                  rv_vld_r, pick_vld_r;
  logic [DW-1:0]         dx_r, best_r, dq_r;

  logic          issue, m_known, upd, cand, fr_new;
  logic [15:0]   m_age, age_inc, new_age;
  logic [COST_WIDTH-1:0] m_cost, cin;
  logic [SW-1:0] sum;
  logic [DW-1:0] dist_new;

  assign root     = NB'(own_r);
  assign cin      = COST_WIDTH'(in_r.link_cost);
  assign upd_addr = AW'(AW'(in_r.link_src) * AW'(NODE_COUNT)) + AW'(in_r.link_dst);
  assign rel_addr = AW'(AW'(x_r) * AW'(NODE_COUNT)) + AW'(cnt_r[NB-1:0]);
  assign issue    = cmd.relax && (cnt_r < (NB+1)'(NODE_COUNT));

  assign m_known = mem_q[MW-1];
  assign m_age   = mem_q[MW-2 -: 16];
  assign m_cost  = mem_q[COST_WIDTH-1:0];
  assign age_inc = (m_age == lsrt_pkg::AGE_MAX) ? m_age : m_age + 16'd1;
  assign new_age = (in_r.opcode == lsrt_pkg::OP_LOCAL) ? (m_known ? age_inc : 16'd0)
                                                       : in_r.link_age;

  assign mem_we = cmd.clr_wr || (cmd.upd_wr && sts.upd_emit);
  assign mem_wa = cmd.clr_wr ? clr_r : upd_addr;
  assign mem_wd = cmd.clr_wr ? '0 : {1'b1, new_age, cin};
  assign mem_re = cmd.upd_rd || issue;
  assign mem_ra = cmd.relax ? rel_addr : upd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  assign sum      = SW'(dx_r) + SW'(m_cost);
  assign upd      = rv_vld_r && m_known && !settled_r[rv_r] && (sum < SW'(dist_r[rv_r]));
  assign dist_new = upd ? DW'(sum) : dist_r[rv_r];
  assign fr_new   = upd || frontier_r[rv_r];
  assign cand     = rv_vld_r && fr_new && !settled_r[rv_r] && (dist_new < best_r);

  always_comb begin
    sts            = '0;
    sts.clr_done   = (clr_r == AW'(DEPTH - 1));
    sts.op         = in_r.opcode;
    sts.nodes_ok   = (int'(in_r.link_src) < NODE_COUNT) && (int'(in_r.link_dst) < NODE_COUNT);
    sts.query_ok   = (int'(own_r) < NODE_COUNT) && (int'(in_r.query_dest) < NODE_COUNT);
    sts.self_q     = (in_r.query_dest == own_r);
    sts.upd_emit   = (in_r.opcode == lsrt_pkg::OP_LOCAL) || !m_known ||
                     (in_r.link_age > m_age);
    sts.relax_done = (cnt_r == (NB+1)'(NODE_COUNT));
    sts.pick_vld   = pick_vld_r || cand;
    sts.pred_ok    = pred_vld_r[hop_r];
    sts.walk_stop  = !pred_vld_r[hop_r] || (pred_r[hop_r] == root) ||
                     (cnt_r == (NB+1)'(NODE_COUNT));
    sts.out_free   = !out_valid_r || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      own_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rv_vld_r    <= 1'b0;
      pick_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) own_r <= cfg_wr_data;
      if (cmd.clr_wr && !sts.clr_done) clr_r <= clr_r + AW'(1);
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      rv_vld_r <= issue;
      if (issue || cmd.walk_step) cnt_r <= cnt_r + (NB+1)'(1);
      else if (cmd.q_init || cmd.next || cmd.walk_start) cnt_r <= '0;
      if (cmd.q_init || cmd.next) pick_vld_r <= 1'b0;
      else if (cand) pick_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_word;
    if (issue) rv_r <= cnt_r[NB-1:0];
    if (cmd.q_init) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        dist_r[i] <= (i == int'(root)) ? DW'(0) : lsrt_pkg::UNREACH;
      end
      pred_r[root]  <= root;
      pred_vld_r    <= NODE_COUNT'(1) << root;
      settled_r     <= NODE_COUNT'(1) << root;
      frontier_r    <= '0;
      x_r           <= root;
      dx_r          <= '0;
      best_r        <= lsrt_pkg::UNREACH;
      hop_r         <= NB'(in_r.query_dest);
    end
    if (upd) begin
      dist_r[rv_r]     <= dist_new;
      pred_r[rv_r]     <= x_r;
      pred_vld_r[rv_r] <= 1'b1;
      frontier_r[rv_r] <= 1'b1;
    end
    if (cand) begin
      best_r <= dist_new;
      pick_r <= rv_r;
    end
    if (cmd.next) begin
      settled_r[pick_r]  <= 1'b1;
      frontier_r[pick_r] <= 1'b0;
      x_r                <= pick_r;
      dx_r               <= best_r;
      best_r             <= lsrt_pkg::UNREACH;
    end
    if (cmd.walk_start) dq_r <= dist_r[hop_r];
    if (cmd.walk_step) hop_r <= pred_r[hop_r];
    if (cmd.upd_wr) begin
      res_r <= '{lsrt_pkg::KIND_FLOOD, in_r.link_src, in_r.link_dst, 16'(cin), new_age,
                 4'd0, 1'b0, 17'd0};
    end
    if (cmd.res_unreach || cmd.res_self || cmd.res_hop) begin
      res_r <= '{lsrt_pkg::KIND_ANSWER, 4'd0, 4'd0, 16'd0, 16'd0,
                 cmd.res_self ? own_r : (cmd.res_hop ? 4'(hop_r) : 4'd0),
                 !cmd.res_unreach,
                 cmd.res_unreach ? lsrt_pkg::UNREACH : (cmd.res_self ? 17'd0 : dq_r)};
    end
    if (cmd.emit) out_word_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: tb/tb_link_state_route_table.sv
`timescale 1ns / 1ps
module tb_link_state_route_table;

  localparam int NODES = 16;
  localparam int NO_PRED = 255;
  localparam int FLUSH_CYCLES = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  lsrt_pkg::in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lsrt_pkg::out_word_t out_word;

  link_state_route_table dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // routing table shadow
  logic [15:0] tbl_cost [NODES*NODES];
  logic [15:0] tbl_age  [NODES*NODES];
  logic        tbl_known[NODES*NODES];
  logic [3:0]  my_node;

  lsrt_pkg::in_word_t  pending_words[$];
  lsrt_pkg::out_word_t expected_words[$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_off = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  function automatic lsrt_pkg::out_word_t route_answer(input logic [3:0] dest);
    int dist_v[NODES];
    int pred[NODES];
    bit done[NODES];
    bit front[NODES];
    int x, pick, best, sum, hop, p, i, v;
    lsrt_pkg::out_word_t r;
    r = '0;
    r.result_kind = lsrt_pkg::KIND_ANSWER;
    for (i = 0; i < NODES; i++) begin
      dist_v[i] = 99999; pred[i] = NO_PRED; done[i] = 0; front[i] = 0;
    end
    dist_v[my_node] = 0; pred[my_node] = my_node; done[my_node] = 1;
    x = my_node;
    while (x < NODES) begin
      for (v = 0; v < NODES; v++) begin
        if (tbl_known[x*NODES+v] && !done[v]) begin
          sum = dist_v[x] + tbl_cost[x*NODES+v];
          if (sum < dist_v[v]) begin
            dist_v[v] = sum; pred[v] = x; front[v] = 1;
          end
        end
      end
      best = 99999; pick = NODES;
      for (i = 0; i < NODES; i++)
        if (front[i] && !done[i] && dist_v[i] < best) begin
          best = dist_v[i]; pick = i;
        end
      if (pick < NODES) begin
        front[pick] = 0; done[pick] = 1;
      end
      x = pick;
    end
    if (dest == my_node) begin
      r.next_hop = my_node; r.reachable = 1'b1; r.path_cost = '0;
    end else if (pred[dest] == NO_PRED) begin
      r.path_cost = lsrt_pkg::UNREACH;
    end else begin
      hop = dest;
      for (i = 0; i < NODES; i++) begin
        p = pred[hop];
        if (p == my_node || p >= NODES) break;
        hop = p;
      end
      r.next_hop = 4'(hop); r.reachable = 1'b1; r.path_cost = 17'(dist_v[dest]);
    end
    return r;
  endfunction

  task automatic predict_word(input lsrt_pkg::in_word_t w);
    lsrt_pkg::out_word_t r;
    int e;
    logic [15:0] age;
    r = '0;
    e = w.link_src * NODES + w.link_dst;
    if (w.opcode == lsrt_pkg::OP_LOCAL || w.opcode == lsrt_pkg::OP_MSG) begin
      if (w.opcode == lsrt_pkg::OP_LOCAL) begin
        age = !tbl_known[e] ? 16'd0 :
              (tbl_age[e] == lsrt_pkg::AGE_MAX) ? lsrt_pkg::AGE_MAX : tbl_age[e] + 16'd1;
      end else begin
        if (tbl_known[e] && w.link_age <= tbl_age[e]) return;
        age = w.link_age;
      end
      tbl_cost[e] = w.link_cost; tbl_age[e] = age; tbl_known[e] = 1'b1;
      r.result_kind = lsrt_pkg::KIND_FLOOD;
      r.msg_src = w.link_src; r.msg_dst = w.link_dst;
      r.msg_cost = w.link_cost; r.msg_age = age;
      expected_words.push_back(r);
    end else if (w.opcode == lsrt_pkg::OP_QUERY) begin
      expected_words.push_back(route_answer(w.query_dest));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_word(in_word);
      if (in_valid && in_stall) begin
      end else if (pending_words.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_word <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
        in_word <= '0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        lsrt_pkg::out_word_t x;
        x = expected_words.pop_front();
        if (out_word.result_kind !== x.result_kind) report_mismatch("result_kind");
        if (out_word.msg_src !== x.msg_src) report_mismatch("msg_src");
        if (out_word.msg_dst !== x.msg_dst) report_mismatch("msg_dst");
        if (out_word.msg_cost !== x.msg_cost) report_mismatch("msg_cost");
        if (out_word.msg_age !== x.msg_age) report_mismatch("msg_age");
        if (out_word.next_hop !== x.next_hop) report_mismatch("next_hop");
        if (out_word.reachable !== x.reachable) report_mismatch("reachable");
        if (out_word.path_cost !== x.path_cost) report_mismatch("path_cost");
      end
    end
  end

  function automatic lsrt_pkg::in_word_t link_word(input logic [1:0] op, input int s,
                                                   input int d, input int c, input int a);
    lsrt_pkg::in_word_t w;
    w = '0;
    w.opcode = op; w.link_src = 4'(s); w.link_dst = 4'(d);
    w.link_cost = 16'(c); w.link_age = 16'(a);
    return w;
  endfunction

  function automatic lsrt_pkg::in_word_t query_word(input int q);
    lsrt_pkg::in_word_t w;
    w = '0;
    w.opcode = lsrt_pkg::OP_QUERY; w.query_dest = 4'(q);
    w.link_src = 4'($urandom); w.link_dst = 4'($urandom);
    w.link_cost = 16'($urandom); w.link_age = 16'($urandom);
    return w;
  endfunction

  function automatic lsrt_pkg::in_word_t random_word();
    lsrt_pkg::in_word_t w;
    int k;
    k = $urandom_range(99, 0);
    // small costs keep paths meaningful; a few huge ones test the unreachable limit
    if (k < 35)
      w = link_word(lsrt_pkg::OP_LOCAL, $urandom_range(15, 0), $urandom_range(15, 0),
                    ($urandom_range(9, 0) == 0) ? $urandom_range(65535, 0)
                                                : $urandom_range(60, 0), 0);
    else if (k < 60)
      w = link_word(lsrt_pkg::OP_MSG, $urandom_range(15, 0), $urandom_range(15, 0),
                    ($urandom_range(9, 0) == 0) ? $urandom_range(65535, 0)
                                                : $urandom_range(60, 0),
                    ($urandom_range(4, 0) == 0) ? $urandom_range(65535, 0)
                                                : $urandom_range(6, 0));
    else if (k < 95)
      w = query_word($urandom_range(15, 0));
    else begin
      w = link_word(OP_UNUSED, $urandom_range(15, 0), $urandom_range(15, 0),
                    $urandom_range(65535, 0), $urandom_range(65535, 0));
      w.query_dest = 4'($urandom);
    end
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic write_own_node(input logic [3:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    my_node = v;
  endtask

  initial begin
    int i, ph;
    for (i = 0; i < NODES*NODES; i++) begin
      tbl_known[i] = 1'b0; tbl_cost[i] = '0; tbl_age[i] = '0;
    end
    my_node = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    pending_words.push_back(query_word(0));
    pending_words.push_back(query_word(5));
    pending_words.push_back(link_word(lsrt_pkg::OP_LOCAL, 0, 1, 10, 0));
    pending_words.push_back(link_word(lsrt_pkg::OP_LOCAL, 0, 1, 4, 0));
    pending_words.push_back(link_word(lsrt_pkg::OP_LOCAL, 1, 2, 3, 0));
    pending_words.push_back(link_word(lsrt_pkg::OP_LOCAL, 0, 2, 7, 0));
    pending_words.push_back(link_word(lsrt_pkg::OP_MSG, 2, 15, 65535, 65535));
    pending_words.push_back(link_word(lsrt_pkg::OP_MSG, 2, 15, 1, 65535));
    pending_words.push_back(link_word(lsrt_pkg::OP_MSG, 2, 15, 1, 100));
    pending_words.push_back(link_word(lsrt_pkg::OP_MSG, 15, 3, 0, 0));
    pending_words.push_back(link_word(lsrt_pkg::OP_MSG, 15, 3, 2, 0));
    pending_words.push_back(link_word(lsrt_pkg::OP_MSG, 15, 3, 2, 1));
    pending_words.push_back(query_word(2));
    pending_words.push_back(query_word(15));
    pending_words.push_back(query_word(3));
    pending_words.push_back(link_word(lsrt_pkg::OP_MSG, 1, 0, 99998, 65534));
    pending_words.push_back(link_word(lsrt_pkg::OP_LOCAL, 1, 0, 99998, 0));
    pending_words.push_back(link_word(lsrt_pkg::OP_LOCAL, 1, 0, 65535, 0));
    pending_words.push_back(link_word(lsrt_pkg::OP_MSG, 4, 5, 50000, 0));
    pending_words.push_back(link_word(lsrt_pkg::OP_MSG, 0, 4, 50000, 0));
    pending_words.push_back(query_word(5));
    pending_words.push_back(link_word(OP_UNUSED, 15, 15, 65535, 65535));
    pending_words.push_back(query_word(4));
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        3: begin send_idle_pct = 27; recv_stall_pct = 27; end
        4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      write_own_node(ph == 0 ? 4'd15 : ph == 4 ? 4'd0 : 4'($urandom_range(15, 0)));
      if (ph == 4) hold_off = 3000;
      for (i = 0; i < 90; i++) pending_words.push_back(random_word());
      wait_drained();
    end

    if (errors == 0) $display("PASS link_state_route_table");
    else $display("FAIL link_state_route_table");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL link_state_route_table");
    $finish;
  end

endmodule
